// ===== rtl/core/modexp_pkg.sv =====
// Shared widths and types for the modular exponentiation block.
package modexp_pkg;

  localparam int FIELD_WIDTH   = 32;
  localparam int OPERAND_WIDTH = 32;
  localparam int STEP_WIDTH    = $clog2(OPERAND_WIDTH);
  localparam int SUM_WIDTH     = OPERAND_WIDTH + 2;

  typedef logic [FIELD_WIDTH-1:0]   field_t;
  typedef logic [OPERAND_WIDTH-1:0] opnd_t;
  typedef logic [STEP_WIDTH-1:0]    step_cnt_t;
  typedef logic [SUM_WIDTH-1:0]     sum_t;

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply modular exponentiation.
// Usage:
//   Input channel (in_valid / in_stall) carries base_value, exponent_value
//   and modulus_value. A transaction is taken only while the block is idle;
//   in_stall stays high for the whole computation.
//   Output channel (out_valid / out_stall) returns power_result and
//   zero_modulus_error, one transaction per input transaction.
//   Sequence: a zero modulus goes straight to the write step. Otherwise the
//   base is first reduced, then each exponent bit up to the highest set bit
//   costs one modular square plus, when the bit is set, one modular
//   multiply, with a sequencing step per bit. One item is in work at a
//   time. The single bit-serial modular multiplier, one multiplier bit per
//   cycle, is shared by the reduce, multiply and square steps.
//   A zero exponent returns 1 even for a modulus of one.
//   The result waits in an output register while out_stall is high; the
//   next input transaction is taken once that result is stored.
//   Reset (rst, synchronous) drops any work in progress and empties the
//   output register.
module modular_exponentiation (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  modexp_pkg::field_t  base_value,
  input  modexp_pkg::field_t  exponent_value,
  input  modexp_pkg::field_t  modulus_value,
  output logic                out_valid,
  input  logic                out_stall,
  output modexp_pkg::field_t  power_result,
  output logic                zero_modulus_error
);
  import modexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_LOOP   = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_SQUARE = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;

  logic [2:0] state;
  opnd_t      modr;
  opnd_t      expo;
  opnd_t      acc;
  opnd_t      sq;
  opnd_t      res;
  logic       err;

  logic       mm_start;
  opnd_t      mm_x;
  opnd_t      mm_y;
  logic       mm_busy;
  logic       mm_done;
  opnd_t      mm_result;
  logic       in_take;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  modexp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (modr),
    .busy   (mm_busy),
    .done   (mm_done),
    .result (mm_result)
  );

  always_comb begin
    mm_start = 1'b0;
    mm_x     = sq;
    mm_y     = sq;
    unique case (state)
      ST_REDUCE: begin
        mm_x = opnd_t'(1);
        mm_y = opnd_t'(base_value);
        mm_start = !mm_busy && !mm_done && (expo == '1) && 1'b0;
      end
      ST_LOOP: begin
        if (expo != '0) begin
          mm_start = 1'b1;
          if (expo[0]) begin
            mm_x = acc;
          end
        end
      end
      ST_MULT: begin
        mm_start = mm_done;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
    if (in_take && (opnd_t'(modulus_value) != '0)) begin
      mm_start = 1'b1;
      mm_x     = opnd_t'(1);
      mm_y     = opnd_t'(base_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= (opnd_t'(modulus_value) == '0) ? ST_WRITE : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mm_done) begin
            state <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (expo == '0) begin
            state <= ST_WRITE;
          end else begin
            state <= expo[0] ? ST_MULT : ST_SQUARE;
          end
        end
        ST_MULT: begin
          if (mm_done) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mm_done) begin
            state <= ST_LOOP;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      modr <= opnd_t'(modulus_value);
      expo <= opnd_t'(exponent_value);
      acc  <= opnd_t'(1);
      res  <= '0;
      err  <= (opnd_t'(modulus_value) == '0);
    end else begin
      unique case (state)
        ST_REDUCE: begin
          if (mm_done) begin
            sq <= mm_result;
          end
        end
        ST_LOOP: begin
          if (expo == '0) begin
            res <= acc;
          end
        end
        ST_MULT: begin
          if (mm_done) begin
            acc <= mm_result;
          end
        end
        ST_SQUARE: begin
          if (mm_done) begin
            sq   <= mm_result;
            expo <= {1'b0, expo[OPERAND_WIDTH-1:1]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_WRITE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WRITE) && out_free) begin
      power_result       <= FIELD_WIDTH'(res);
      zero_modulus_error <= err;
    end
  end

endmodule

// ===== rtl/core/modexp_mulmod.sv =====
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module modexp_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  modexp_pkg::opnd_t  x,
  input  modexp_pkg::opnd_t  y,
  input  modexp_pkg::opnd_t  m,
  output logic               busy,
  output logic               done,
  output modexp_pkg::opnd_t  result
);
  import modexp_pkg::*;

  opnd_t     acc;
  opnd_t     xr;
  opnd_t     yr;
  step_cnt_t cnt;
  sum_t      sum;
  sum_t      m1;
  sum_t      m2;
  sum_t      diff1;
  sum_t      diff2;
  opnd_t     acc_next;

  assign result = acc;

  always_comb begin
    m1    = {2'b00, m};
    m2    = {1'b0, m, 1'b0};
    sum   = {1'b0, acc, 1'b0} + (yr[OPERAND_WIDTH-1] ? {2'b00, xr} : '0);
    diff1 = sum - m1;
    diff2 = sum - m2;
    priority if (sum >= m2) begin
      acc_next = diff2[OPERAND_WIDTH-1:0];
    end else if (sum >= m1) begin
      acc_next = diff1[OPERAND_WIDTH-1:0];
    end else begin
      acc_next = sum[OPERAND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      cnt <= STEP_WIDTH'(OPERAND_WIDTH - 1);
    end else if (busy) begin
      acc <= acc_next;
      yr  <= {yr[OPERAND_WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the modular exponentiation block.
module testbench;
  import modexp_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 64;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SLOW} rx_pattern_t;

  typedef struct packed {
    field_t power;
    logic   zero_mod;
  } power_t;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  field_t base_value;
  field_t exponent_value;
  field_t modulus_value;
  logic   out_valid;
  logic   out_stall;
  field_t power_result;
  logic   zero_modulus_error;

  power_t      expected_powers[$];
  rx_pattern_t rx_pattern;
  bit          gaps_on;
  int          burst_left;
  int          stall_run;
  int          error_count;
  int          sent_count;
  int          checked_count;
  int          zero_mod_count;
  int          wide_exp_count;
  int          cycle_count;

  modular_exponentiation u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .base_value         (base_value),
    .exponent_value     (exponent_value),
    .modulus_value      (modulus_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .power_result       (power_result),
    .zero_modulus_error (zero_modulus_error)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic power_t predict_power(field_t b, field_t e, field_t m);
    power_t      res;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] md;
    field_t      ex;
    md = {32'd0, m};
    ex = e;
    res.zero_mod = 1'b0;
    if (m == '0) begin
      res.power    = '0;
      res.zero_mod = 1'b1;
      return res;
    end
    acc = 64'd1;
    sq  = {32'd0, b} % md;
    while (ex != '0) begin
      if (ex[0]) acc = ((acc % md) * sq) % md;
      sq = (sq * sq) % md;
      ex = ex >> 1;
    end
    res.power = acc[FIELD_WIDTH-1:0];
    return res;
  endfunction

  // Receive side: check each transaction, then pick the next stall value.
  always @(posedge clk) begin
    power_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        $error("unexpected result: power_result %h zero_modulus_error %b",
               power_result, zero_modulus_error);
        error_count++;
      end else begin
        exp_item = expected_powers.pop_front();
        checked_count++;
        if (power_result !== exp_item.power) begin
          $error("power_result: expected %h, actual %h", exp_item.power, power_result);
          error_count++;
        end
        if (zero_modulus_error !== exp_item.zero_mod) begin
          $error("zero_modulus_error: expected %b, actual %b",
                 exp_item.zero_mod, zero_modulus_error);
          error_count++;
        end
      end
    end
    case (rx_pattern)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_CHOPPY: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 24);
          out_stall <= !out_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** modular_exponentiation: FAILED **");
      $finish;
    end
  end

  // Drop valid for a while and put junk on the idle payload.
  task automatic pause_input(input int cycles);
    in_valid       <= 1'b0;
    base_value     <= $urandom;
    exponent_value <= $urandom;
    modulus_value  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_operands(input field_t b, input field_t e, input field_t m);
    in_valid       <= 1'b1;
    base_value     <= b;
    exponent_value <= e;
    modulus_value  <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_powers.push_back(predict_power(b, e, m));
    sent_count++;
    if (m == '0) zero_mod_count++;
    if (e[FIELD_WIDTH-1]) wide_exp_count++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 6);
        pause_input($urandom_range(1, 12));
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic random_operands(output field_t b, output field_t e, output field_t m);
    case ($urandom_range(0, 19))
      0:       m = '0;
      1:       m = 32'd1;
      2, 3:    m = $urandom_range(2, 255);
      4:       m = 32'hFFFF_FFFF - $urandom_range(0, 16);
      default: m = $urandom;
    endcase
    case ($urandom_range(0, 15))
      0:       e = '0;
      1, 2:    e = $urandom;
      default: e = $urandom & ((32'd1 << $urandom_range(1, 10)) - 32'd1);
    endcase
    case ($urandom_range(0, 9))
      0:       b = '0;
      1:       b = 32'hFFFF_FFFF;
      2:       b = m;
      3:       b = m - 32'd1;
      default: b = $urandom;
    endcase
  endtask

  task automatic run_random(input int count);
    field_t b;
    field_t e;
    field_t m;
    repeat (count) begin
      random_operands(b, e, m);
      send_operands(b, e, m);
    end
  endtask

  task automatic test_special_cases();
    rx_pattern <= RX_FREE;
    gaps_on = 1'b0;
    send_operands(32'd5, 32'd7, 32'd0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_operands(32'd0, 32'd0, 32'd0);
    send_operands(32'd12345, 32'd0, 32'd1);
    send_operands(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_operands(32'd7, 32'd1, 32'd1);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
  endtask

  task automatic test_extremes();
    rx_pattern <= RX_CHOPPY;
    gaps_on = 1'b1;
    send_operands(32'd0, 32'd5, 32'd13);
    send_operands(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    send_operands(32'd2, 32'd31, 32'hFFFF_FFFF);
    send_operands(32'd3, 32'd1, 32'd2);
    send_operands(32'd100, 32'd1, 32'd7);
    send_operands(32'd2, 32'h8000_0000, 32'hFFFF_FFFB);
    send_operands(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFB);
    send_operands(32'd7, 32'hAAAA_AAAA, 32'h8000_0000);
    send_operands(32'd5, 32'h5555_5555, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_steady();
    rx_pattern <= RX_FREE;
    gaps_on = 1'b0;
    run_random(60);
  endtask

  task automatic test_random_paced();
    rx_pattern <= RX_CHOPPY;
    gaps_on = 1'b1;
    run_random(100);
  endtask

  task automatic test_random_backpressure();
    rx_pattern <= RX_SLOW;
    gaps_on = 1'b1;
    run_random(110);
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    out_stall      = 1'b0;
    base_value     = '0;
    exponent_value = '0;
    modulus_value  = '0;
    rx_pattern     = RX_FREE;
    gaps_on        = 1'b0;
    burst_left     = 0;
    stall_run      = 0;
    error_count    = 0;
    sent_count     = 0;
    checked_count  = 0;
    zero_mod_count = 0;
    wide_exp_count = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_extremes();
    test_random_steady();
    test_random_paced();
    test_random_backpressure();

    pause_input(0);
    rx_pattern <= RX_FREE;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_powers.size() != 0) begin
      $error("%0d expected results never arrived", expected_powers.size());
      error_count++;
    end

    $display("Run covered %0d transactions and %0d checked results under varied pacing.",
             sent_count, checked_count);
    $display("Of these, %0d had a zero modulus and %0d a full-width exponent; %0d errors.",
             zero_mod_count, wide_exp_count, error_count);
    if (error_count == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule
